/* design/bdb_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the de Boor B-spline evaluator.
// No dependencies; every design file imports this package.
package bdb_pkg;

    localparam int DEF_MAX_KNOTS = 64;
    localparam int DEF_MAX_ORDER = 8;
    localparam int DEF_FRAC_BITS = 16;

    localparam int CMD_W      = 2;
    localparam int SLOT_W     = 6;
    localparam int DATA_W     = 32;
    localparam int ORDER_W    = 4;
    localparam int COUNT_W    = 7;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam int J_W        = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_KNOT  = 2'd0,
        CMD_LOAD_COEFF = 2'd1,
        CMD_EVAL       = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_OUTSIDE  = 2'd1,
        ST_DIV_ZERO = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORDER = 1'b0,
        CFG_COUNT = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_SRCH1, S_SRCH2, S_FILL, S_T0, S_T1, S_T2, S_TS, S_TW,
        S_FIN, S_CAP, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        A_IDLE, A_MUL, A_DIV, A_DONE
    } t_arith_state;

    typedef struct packed {
        logic                     knot_we;
        logic                     coeff_we;
        logic [SLOT_W-1:0]        slot;
        logic signed [DATA_W-1:0] data;
    } t_tbl_wr;

endpackage

/* design/bspline_de_boor_evaluator.sv */
`timescale 1ns / 1ps
// Top level of the de Boor B-spline evaluator: sequencer, configuration and
// triangle store. Depends on bdb_pkg, bdb_tables and bdb_arith.
//
// Input channel (i_valid/o_ready) carries i_cmd, i_slot, i_operand. Load knot
// and load coefficient items write the tables in the cycle they are taken and
// produce no result. An evaluate item produces one result on the output
// channel (o_valid/i_ready): o_spline_value and o_status.
// An evaluate item searches the knot intervals, one per cycle, then runs
// k*(k-1)/2 triangle steps for order k. Each step runs the single shared
// multiply/divide unit: a bit-serial multiply-accumulate, then a restoring
// divide of the PW-bit sum (PW, the product width, is 67 bits by default).
// o_ready is low while an item is in progress and while a result waits; a
// stalled receiver holds the block with its result steady.
// After reset the coefficient table is cleared entry by entry with
// o_ready low; configuration writes are taken at any time.
module bspline_de_boor_evaluator #(
    parameter int MAX_KNOTS = bdb_pkg::DEF_MAX_KNOTS,
    parameter int MAX_ORDER = bdb_pkg::DEF_MAX_ORDER,
    parameter int FRAC_BITS = bdb_pkg::DEF_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bdb_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bdb_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [bdb_pkg::CMD_W-1:0]           i_cmd,
    input  logic [bdb_pkg::SLOT_W-1:0]          i_slot,
    input  logic signed [bdb_pkg::DATA_W-1:0]   i_operand,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [bdb_pkg::DATA_W-1:0]   o_spline_value,
    output logic [bdb_pkg::STATUS_W-1:0]        o_status
);
    import bdb_pkg::*;

    localparam int AW  = $clog2(MAX_KNOTS);
    localparam int KB  = $clog2(MAX_ORDER + 1);
    localparam int TA  = $clog2(MAX_ORDER);
    localparam int PADB = FRAC_BITS + KB;
    localparam int KW  = ((PADB > DATA_W - 1) ? PADB : DATA_W - 1) + 2;

    t_state                   r_state, n_state;
    logic [ORDER_W-1:0]       r_order;
    logic [COUNT_W-1:0]       r_count;
    logic [KB-1:0]            r_k, n_k;
    logic [COUNT_W-1:0]       r_n, n_n;
    logic signed [DATA_W-1:0] r_x, n_x;
    logic [J_W-1:0]           r_j, n_j;
    logic [J_W-1:0]           r_off, n_off;
    logic [TA-1:0]            r_jh, n_jh;
    logic [KB-1:0]            r_p, n_p;
    logic signed [KW-1:0]     r_tlo, n_tlo;
    logic signed [KW-1:0]     r_tj, n_tj;
    logic signed [KW-1:0]     r_tr, n_tr;
    logic signed [DATA_W-1:0] r_da, n_da;
    logic signed [DATA_W-1:0] r_db, n_db;
    logic signed [DATA_W-1:0] r_val, n_val;
    logic [STATUS_W-1:0]      r_status, n_status;

    logic signed [DATA_W-1:0] r_tri [MAX_ORDER];
    logic signed [DATA_W-1:0] r_tri_q;
    logic [TA-1:0]            tri_raddr;
    logic                     tri_we;
    logic [TA-1:0]            tri_waddr;
    logic signed [DATA_W-1:0] tri_wdata;

    t_tbl_wr                  tbl_wr;
    logic [AW-1:0]            tbl_raddr;
    logic signed [DATA_W-1:0] knot_q, coeff_q, knot0;
    logic                     tbl_busy;

    logic [KB-1:0]            k_cfg;
    logic [COUNT_W-1:0]       n_cfg;
    logic [J_W-1:0]           idx, lim, kj_diff;
    logic signed [KW-1:0]     knot_pad, x_ext;
    logic signed [DATA_W-1:0] coeff_pad;
    logic                     below_k;
    logic                     accept;
    logic                     arith_start, arith_done;
    logic signed [DATA_W-1:0] arith_res;

    bdb_tables #(
        .MAX_KNOTS (MAX_KNOTS),
        .AW        (AW)
    ) u_tables (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (tbl_wr),
        .i_raddr   (tbl_raddr),
        .o_knot_q  (knot_q),
        .o_coeff_q (coeff_q),
        .o_knot0   (knot0),
        .o_busy    (tbl_busy)
    );

    bdb_arith #(
        .KW (KW)
    ) u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (arith_start),
        .i_x      (r_x),
        .i_tj     (r_tj),
        .i_tr     (r_tr),
        .i_da     (r_da),
        .i_db     (r_db),
        .o_done   (arith_done),
        .o_result (arith_res)
    );

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    always_comb begin
        tbl_wr.knot_we  = accept && i_cmd == CMD_LOAD_KNOT
                          && 32'(i_slot) < MAX_KNOTS;
        tbl_wr.coeff_we = accept && i_cmd == CMD_LOAD_COEFF
                          && 32'(i_slot) < MAX_KNOTS;
        tbl_wr.slot     = i_slot;
        tbl_wr.data     = i_operand;
    end

    always_comb begin
        if (r_order == '0) begin
            k_cfg = KB'(1);
        end else if (32'(r_order) > MAX_ORDER) begin
            k_cfg = KB'(MAX_ORDER);
        end else begin
            k_cfg = KB'(r_order);
        end
        n_cfg = (32'(r_count) > MAX_KNOTS) ? COUNT_W'(MAX_KNOTS) : r_count;
    end

    // padded knot and coefficient of r_j, from the read issued last cycle
    always_comb begin
        below_k   = r_j < J_W'(r_k);
        kj_diff   = J_W'(r_k) - r_j;
        x_ext     = KW'(r_x);
        knot_pad  = below_k ? KW'(knot0) - (KW'(kj_diff) << FRAC_BITS) : KW'(knot_q);
        coeff_pad = below_k ? '0 : coeff_q;
        idx       = n_j - J_W'(n_k);
        lim       = J_W'(n_n) - 1'b1;
        if (idx > lim) begin
            idx = lim;
        end
        tbl_raddr = AW'(idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_W'(4);
            r_count <= COUNT_W'(2);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ORDER: r_order <= i_cfg_wdata[ORDER_W-1:0];
                CFG_COUNT: r_count <= i_cfg_wdata[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_n      <= n_n;
        r_x      <= n_x;
        r_j      <= n_j;
        r_off    <= n_off;
        r_jh     <= n_jh;
        r_p      <= n_p;
        r_tlo    <= n_tlo;
        r_tj     <= n_tj;
        r_tr     <= n_tr;
        r_da     <= n_da;
        r_db     <= n_db;
        r_val    <= n_val;
        r_status <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (tri_we) begin
            r_tri[tri_waddr] <= tri_wdata;
        end
        r_tri_q <= r_tri[tri_raddr];
    end

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_n         = r_n;
        n_x         = r_x;
        n_j         = r_j;
        n_off       = r_off;
        n_jh        = r_jh;
        n_p         = r_p;
        n_tlo       = r_tlo;
        n_tj        = r_tj;
        n_tr        = r_tr;
        n_da        = r_da;
        n_db        = r_db;
        n_val       = r_val;
        n_status    = r_status;
        tri_raddr   = '0;
        tri_we      = 1'b0;
        tri_waddr   = r_jh;
        tri_wdata   = coeff_pad;
        arith_start = 1'b0;
        case (r_state)
            S_CLR: begin
                if (!tbl_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept && i_cmd == CMD_EVAL) begin
                    n_k = k_cfg;
                    n_n = n_cfg;
                    n_x = i_operand;
                    n_j = J_W'(k_cfg);
                    if (n_cfg <= COUNT_W'(1)) begin
                        n_val    = '0;
                        n_status = ST_OUTSIDE;
                        n_state  = S_OUT;
                    end else begin
                        n_state = S_SRCH1;
                    end
                end
            end
            S_SRCH1: begin
                n_tlo   = knot_pad;
                n_j     = r_j + 1'b1;
                n_state = S_SRCH2;
            end
            S_SRCH2: begin
                if (r_tlo <= x_ext && x_ext < knot_pad) begin
                    n_off   = r_j - J_W'(r_k);
                    n_j     = r_j - J_W'(r_k);
                    n_jh    = '0;
                    n_state = S_FILL;
                end else if (r_j < J_W'(r_n) + J_W'(r_k) - 1'b1) begin
                    n_tlo = knot_pad;
                    n_j   = r_j + 1'b1;
                end else begin
                    n_val    = '0;
                    n_status = ST_OUTSIDE;
                    n_state  = S_OUT;
                end
            end
            S_FILL: begin
                tri_we    = 1'b1;
                tri_wdata = coeff_pad;
                if (r_jh == TA'(r_k - 1'b1)) begin
                    n_p  = KB'(1);
                    n_jh = TA'(r_k - 1'b1);
                    n_state = (r_k == KB'(1)) ? S_FIN : S_T0;
                end else begin
                    n_jh = r_jh + 1'b1;
                    n_j  = r_j + 1'b1;
                end
            end
            S_T0: begin
                n_j       = J_W'(r_jh) + r_off;
                tri_raddr = r_jh;
                n_state   = S_T1;
            end
            S_T1: begin
                n_tj      = knot_pad;
                n_da      = r_tri_q;
                n_j       = J_W'(r_jh) + r_off + J_W'(r_k) - J_W'(r_p);
                tri_raddr = r_jh - 1'b1;
                n_state   = S_T2;
            end
            S_T2: begin
                n_tr = knot_pad;
                n_db = r_tri_q;
                if (knot_pad == r_tj) begin
                    n_val    = '0;
                    n_status = ST_DIV_ZERO;
                    n_state  = S_OUT;
                end else begin
                    n_state = S_TS;
                end
            end
            S_TS: begin
                arith_start = 1'b1;
                n_state     = S_TW;
            end
            S_TW: begin
                if (arith_done) begin
                    tri_we    = 1'b1;
                    tri_wdata = arith_res;
                    if (KB'(r_jh) > r_p) begin
                        n_jh    = r_jh - 1'b1;
                        n_state = S_T0;
                    end else if (r_p + 1'b1 < r_k) begin
                        n_p     = r_p + 1'b1;
                        n_jh    = TA'(r_k - 1'b1);
                        n_state = S_T0;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                tri_raddr = TA'(r_k - 1'b1);
                n_state   = S_CAP;
            end
            S_CAP: begin
                n_val    = r_tri_q;
                n_status = ST_OK;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid        = (r_state == S_OUT);
    assign o_spline_value = r_val;
    assign o_status       = r_status;

`ifndef NO_ASSERTIONS
    a_busy_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input taken while a result waits");
    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_spline_value == '0))
        else $error("nonzero value with error status");
    a_eval_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd == CMD_EVAL) |=> !o_ready)
        else $error("ready right after an evaluate item");
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        arith_done |-> (r_state == S_TW))
        else $error("step unit finished outside its wait state");
`endif

endmodule

/* design/bdb_tables.sv */
`timescale 1ns / 1ps
// Knot and coefficient memories with registered reads and a coefficient clear sweep.
// Depends on bdb_pkg.
module bdb_tables #(
    parameter int MAX_KNOTS = bdb_pkg::DEF_MAX_KNOTS,
    parameter int AW        = $clog2(MAX_KNOTS)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bdb_pkg::t_tbl_wr                 i_wr,
    input  logic [AW-1:0]                    i_raddr,
    output logic signed [bdb_pkg::DATA_W-1:0] o_knot_q,
    output logic signed [bdb_pkg::DATA_W-1:0] o_coeff_q,
    output logic signed [bdb_pkg::DATA_W-1:0] o_knot0,
    output logic                             o_busy
);
    import bdb_pkg::*;

    logic signed [DATA_W-1:0] r_knot_mem  [MAX_KNOTS];
    logic signed [DATA_W-1:0] r_coeff_mem [MAX_KNOTS];
    logic [AW-1:0]            r_clr;
    logic                     r_busy;
    logic signed [DATA_W-1:0] r_knot0;
    logic [AW-1:0]            waddr;

    assign waddr = AW'(i_wr.slot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_clr <= r_clr + 1'b1;
            if (r_clr == AW'(MAX_KNOTS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.knot_we) begin
            r_knot_mem[waddr] <= i_wr.data;
        end
        o_knot_q <= r_knot_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_coeff_mem[r_clr] <= '0;
        end else if (i_wr.coeff_we) begin
            r_coeff_mem[waddr] <= i_wr.data;
        end
        o_coeff_q <= r_coeff_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.knot_we && waddr == '0) begin
            r_knot0 <= i_wr.data;
        end
    end

    assign o_knot0 = r_knot0;
    assign o_busy  = r_busy;

endmodule

/* design/bdb_arith.sv */
`timescale 1ns / 1ps
// Shared de Boor step unit: bit-serial multiply-accumulate, then restoring
// divide with saturation. Depends on bdb_pkg.
module bdb_arith #(
    parameter int KW = 40
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [bdb_pkg::DATA_W-1:0] i_x,
    input  logic signed [KW-1:0]              i_tj,
    input  logic signed [KW-1:0]              i_tr,
    input  logic signed [bdb_pkg::DATA_W-1:0] i_da,
    input  logic signed [bdb_pkg::DATA_W-1:0] i_db,
    output logic                              o_done,
    output logic signed [bdb_pkg::DATA_W-1:0] o_result
);
    import bdb_pkg::*;

    localparam int PW = KW + DATA_W + 2;
    localparam int RW = KW + 1;
    localparam int CW = $clog2(PW);

    t_arith_state             r_state;
    logic signed [PW-1:0]     r_a;
    logic signed [PW-1:0]     r_a2;
    logic [DATA_W-1:0]        r_m;
    logic [DATA_W-1:0]        r_db;
    logic [4:0]               r_bit;
    logic                     r_ph;
    logic signed [PW-1:0]     r_acc;
    logic [PW-1:0]            r_num;
    logic [RW-1:0]            r_d;
    logic                     r_dneg;
    logic [RW-1:0]            r_rem;
    logic [DATA_W:0]          r_q;
    logic                     r_ovf;
    logic                     r_neg;
    logic [CW-1:0]            r_cnt;

    logic signed [RW-1:0]     den;
    logic signed [PW-1:0]     addend;
    logic signed [PW-1:0]     acc_nx;
    logic [RW-1:0]            rem2;
    logic                     ge;

    assign den    = RW'(i_tr) - RW'(i_tj);
    assign addend = r_m[0] ? ((r_bit == 5'd31) ? -r_a : r_a) : '0;
    assign acc_nx = r_acc + addend;
    assign rem2   = {r_rem[RW-2:0], r_num[PW-1]};
    assign ge     = rem2 >= r_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
        end else begin
            case (r_state)
                A_IDLE: begin
                    if (i_start) begin
                        r_state <= A_MUL;
                    end
                end
                A_MUL: begin
                    if (r_bit == 5'd31 && r_ph) begin
                        r_state <= A_DIV;
                    end
                end
                A_DIV: begin
                    if (r_cnt == CW'(PW - 1)) begin
                        r_state <= A_DONE;
                    end
                end
                A_DONE:  r_state <= A_IDLE;
                default: r_state <= A_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            A_IDLE: begin
                r_a    <= PW'(i_x) - PW'(i_tj);
                r_a2   <= PW'(i_tr) - PW'(i_x);
                r_m    <= i_da;
                r_db   <= i_db;
                r_bit  <= '0;
                r_ph   <= 1'b0;
                r_acc  <= '0;
                r_dneg <= den[RW-1];
                r_d    <= den[RW-1] ? RW'(-den) : RW'(den);
            end
            A_MUL: begin
                r_acc <= acc_nx;
                if (r_bit == 5'd31) begin
                    r_bit <= '0;
                    r_ph  <= 1'b1;
                    r_a   <= r_a2;
                    r_m   <= r_db;
                    r_neg <= acc_nx[PW-1] ^ r_dneg;
                    r_num <= acc_nx[PW-1] ? PW'(-acc_nx) : PW'(acc_nx);
                    r_rem <= '0;
                    r_q   <= '0;
                    r_ovf <= 1'b0;
                    r_cnt <= '0;
                end else begin
                    r_bit <= r_bit + 1'b1;
                    r_a   <= r_a <<< 1;
                    r_m   <= r_m >> 1;
                end
            end
            A_DIV: begin
                r_num <= r_num << 1;
                r_rem <= ge ? rem2 - r_d : rem2;
                r_q   <= {r_q[DATA_W-1:0], ge};
                r_ovf <= r_ovf | r_q[DATA_W];
                r_cnt <= r_cnt + 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (r_neg) begin
            if (r_ovf || r_q > {2'b01, {(DATA_W-1){1'b0}}}) begin
                o_result = {1'b1, {(DATA_W-1){1'b0}}};
            end else begin
                o_result = -r_q[DATA_W-1:0];
            end
        end else begin
            if (r_ovf || r_q[DATA_W] || r_q[DATA_W-1]) begin
                o_result = {1'b0, {(DATA_W-1){1'b1}}};
            end else begin
                o_result = r_q[DATA_W-1:0];
            end
        end
    end

    assign o_done = (r_state == A_DONE);

endmodule

/* tb/bdb_eval_checker.sv */
`timescale 1ns / 1ps
// Checker for the de Boor B-spline evaluator: tracks tables and configuration,
// predicts each evaluate result and compares it. Depends on bdb_pkg.
module bdb_eval_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bdb_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bdb_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                i_valid,
    input  logic                                i_ready_in,
    input  logic [bdb_pkg::CMD_W-1:0]           i_cmd,
    input  logic [bdb_pkg::SLOT_W-1:0]          i_slot,
    input  logic signed [bdb_pkg::DATA_W-1:0]   i_operand,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [bdb_pkg::DATA_W-1:0]   i_spline_value,
    input  logic [bdb_pkg::STATUS_W-1:0]        i_status,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_checked
);
    import bdb_pkg::*;

    localparam int NKNOT = DEF_MAX_KNOTS;
    localparam int NORD  = DEF_MAX_ORDER;
    localparam longint ONE = longint'(1) << DEF_FRAC_BITS;

    logic signed [DATA_W-1:0] knot_tbl [NKNOT];
    logic signed [DATA_W-1:0] coeff_tbl [NKNOT];
    logic [ORDER_W-1:0]       order_reg;
    logic [COUNT_W-1:0]       count_reg;
    logic signed [DATA_W-1:0] value_q [$];
    t_status                  status_q [$];
    logic signed [DATA_W-1:0] want_val;
    t_status                  want_st;
    int                       bad;

    initial begin
        o_fail_count = 0;
        o_checked = 0;
        for (int i = 0; i < NKNOT; i++) knot_tbl[i] = '0;
    end

    assign o_pending = value_q.size();

    function automatic longint knot_at(input int j, input int k, input int n);
        int i;
        if (j < k) return longint'(knot_tbl[0]) - longint'(k - j) * ONE;
        i = j - k;
        if (i > n - 1) i = n - 1;
        return longint'(knot_tbl[i]);
    endfunction

    function automatic longint coeff_at(input int j, input int k);
        if (j < k || j - k >= NKNOT) return 0;
        return longint'(coeff_tbl[j - k]);
    endfunction

    function automatic void spline_at(input logic signed [DATA_W-1:0] x,
                                      output logic signed [DATA_W-1:0] val,
                                      output t_status st);
        int k, n, found, off, j;
        longint xl, tj, tr, den;
        longint tri_r [NORD];
        logic signed [127:0] a1, b1, a2, b2, num, den_w, q;
        xl = x;
        k = (order_reg == 0) ? 1 : ((order_reg > NORD) ? NORD : int'(order_reg));
        n = (count_reg > NKNOT) ? NKNOT : int'(count_reg);
        found = -1;
        val = '0;
        st = ST_OK;
        for (int m = k; m < n + k - 1 && found < 0; m++)
            if (knot_at(m, k, n) <= xl && xl < knot_at(m + 1, k, n)) found = m;
        if (found < 0) begin
            st = ST_OUTSIDE;
        end else begin
            off = found - k + 1;
            for (int h = 0; h < k; h++) tri_r[h] = coeff_at(h + off, k);
            for (int p = 1; p < k && st == ST_OK; p++) begin
                for (int h = k - 1; h >= p && st == ST_OK; h--) begin
                    j = h + off;
                    tj = knot_at(j, k, n);
                    tr = knot_at(j + k - p, k, n);
                    den = tr - tj;
                    if (den == 0) begin
                        st = ST_DIV_ZERO;
                    end else begin
                        a1 = xl - tj;
                        b1 = tri_r[h];
                        a2 = tr - xl;
                        b2 = tri_r[h - 1];
                        num = a1 * b1 + a2 * b2;
                        den_w = den;
                        q = num / den_w;
                        if (q > 128'sd2147483647) tri_r[h] = 64'sd2147483647;
                        else if (q < -128'sd2147483648) tri_r[h] = -64'sd2147483648;
                        else tri_r[h] = longint'(q);
                    end
                end
            end
            if (st == ST_OK) val = tri_r[k - 1];
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NKNOT; i++) coeff_tbl[i] = '0;
            order_reg <= ORDER_W'(4);
            count_reg <= COUNT_W'(2);
            value_q.delete();
            status_q.delete();
        end else begin
            bad = 0;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ORDER: order_reg <= i_cfg_wdata[ORDER_W-1:0];
                    CFG_COUNT: count_reg <= i_cfg_wdata[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_valid && i_ready_in) begin
                case (i_cmd)
                    CMD_LOAD_KNOT:  knot_tbl[i_slot] = i_operand;
                    CMD_LOAD_COEFF: coeff_tbl[i_slot] = i_operand;
                    CMD_EVAL: begin
                        spline_at(i_operand, want_val, want_st);
                        value_q.push_back(want_val);
                        status_q.push_back(want_st);
                    end
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (value_q.size() == 0) begin
                    $display("%0t: result with none expected, value %0d status %0d",
                             $time, i_spline_value, i_status);
                    bad++;
                end else begin
                    want_val = value_q.pop_front();
                    want_st = status_q.pop_front();
                    o_checked <= o_checked + 1;
                    if (i_spline_value !== want_val) begin
                        $display("%0t: spline_value expected %0d, actual %0d",
                                 $time, want_val, i_spline_value);
                        bad++;
                    end
                    if (i_status !== want_st) begin
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, want_st, i_status);
                        bad++;
                    end
                end
            end
            if (bad != 0) o_fail_count <= o_fail_count + bad;
        end
    end
endmodule

/* tb/bspline_de_boor_evaluator_tb.sv */
`timescale 1ns / 1ps
// Top of the B-spline evaluator testbench: clock, reset, stimulus and verdict.
// Depends on bdb_pkg, bspline_de_boor_evaluator and bdb_eval_checker.
module bspline_de_boor_evaluator_tb;
    import bdb_pkg::*;

    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 6000000;
    localparam int HOLD_CYCLES = 3000;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_wdata = '0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic [CMD_W-1:0]         i_cmd = '0;
    logic [SLOT_W-1:0]        i_slot = '0;
    logic signed [DATA_W-1:0] i_operand = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic signed [DATA_W-1:0] o_spline_value;
    logic [STATUS_W-1:0]      o_status;

    int fail_count, pending, checked;
    int items_sent = 0;
    int cycles = 0;
    bit tx_idle = 0, rx_idle = 0;
    int hold_req = 0, hold_seen = 0, hold_left = 0;
    logic signed [DATA_W-1:0] kn_val [64];

    bspline_de_boor_evaluator DUT (.*);

    bdb_eval_checker CHK (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata), .i_valid(i_valid), .i_ready_in(o_ready),
        .i_cmd(i_cmd), .i_slot(i_slot), .i_operand(i_operand),
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_spline_value(o_spline_value),
        .i_status(o_status), .o_fail_count(fail_count), .o_pending(pending),
        .o_checked(checked)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (rx_idle && $urandom_range(0, 99) < 32) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic send(input logic [CMD_W-1:0] c, input int s, input logic [31:0] d);
        while (tx_idle && $urandom_range(0, 99) < 32) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_cmd = c;
        i_slot = s[SLOT_W-1:0];
        i_operand = d;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (c == CMD_LOAD_KNOT) kn_val[s[SLOT_W-1:0]] = d;
        items_sent++;
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input int v);
        drain();
        repeat (16) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_wdata = v[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic [31:0] rand_coeff();
        if ($urandom_range(0, 99) < 80) return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_x(input int nn);
        longint lo, hi, t;
        int r;
        if (nn < 2) return $urandom;
        lo = kn_val[0];
        hi = kn_val[nn - 1];
        if (hi < lo) begin
            t = lo;
            lo = hi;
            hi = t;
        end
        r = $urandom_range(0, 99);
        if (r < 60 && hi - lo < 64'h0FFF_0000)
            return 32'(lo - 65536 + longint'($urandom_range(0, 32'(hi - lo + 131072))));
        if (r < 80) return kn_val[$urandom_range(0, nn - 1)];
        return $urandom;
    endfunction

    task automatic load_tables(input int nn);
        longint v;
        v = longint'($urandom_range(0, 200 << 16)) - (100 << 16);
        for (int i = 0; i < nn; i++) begin
            send(CMD_LOAD_KNOT, i, 32'(v));
            if ($urandom_range(0, 1)) send(CMD_LOAD_COEFF, i, rand_coeff());
            if ($urandom_range(0, 9) != 0)
                v += longint'($urandom_range(1, 3)) * 65536 + $urandom_range(0, 65535);
        end
    endtask

    task automatic run_phase(input int order, input int count, input int n_items,
                             input bit idle, input bit hold, input bit pause);
        int nn, r;
        cfg_write(CFG_ORDER, order);
        cfg_write(CFG_COUNT, count);
        tx_idle = idle;
        rx_idle = idle;
        nn = (count > 64) ? 64 : count;
        load_tables(nn);
        for (int i = 0; i < n_items; i++) begin
            if (i == n_items / 2) begin
                if (hold) hold_req++;
                if (pause) drain();
            end
            r = $urandom_range(0, 99);
            if (r < 68) send(CMD_EVAL, $urandom_range(0, 63), pick_x(nn));
            else if (r < 80)
                send(CMD_LOAD_COEFF, $urandom_range(0, (nn > 0) ? nn - 1 : 0), rand_coeff());
            else if (r < 88 && nn > 0)
                send(CMD_LOAD_KNOT, $urandom_range(0, nn - 1), pick_x(nn));
            else if (r < 94)
                send($urandom_range(0, 1) ? CMD_LOAD_KNOT : CMD_LOAD_COEFF,
                     $urandom_range(0, 63), $urandom);
            else send(CMD_NONE, $urandom_range(0, 63), $urandom);
        end
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        cfg_write(CFG_ORDER, 2);
        cfg_write(CFG_COUNT, 2);
        send(CMD_LOAD_KNOT, 0, 32'h8000_0000);
        send(CMD_LOAD_KNOT, 1, 32'h7FFF_FFFF);
        send(CMD_LOAD_COEFF, 0, 32'h7FFF_FFFF);
        send(CMD_LOAD_COEFF, 1, 32'h8000_0000);
        send(CMD_LOAD_COEFF, 63, 32'hFFFF_FFFF);
        send(CMD_EVAL, 0, 32'h8000_0000);
        send(CMD_EVAL, 63, 32'h0000_0000);
        send(CMD_EVAL, 0, 32'h7FFF_FFFE);
        send(CMD_EVAL, 0, 32'h7FFF_FFFF);
        send(CMD_NONE, 5, 32'h1234_5678);
        cfg_write(CFG_ORDER, 1);
        send(CMD_EVAL, 0, 32'h0001_2345);
        cfg_write(CFG_ORDER, 0);
        send(CMD_EVAL, 0, 32'h0000_0000);
        cfg_write(CFG_ORDER, 15);
        send(CMD_EVAL, 0, 32'h4000_0000);
        cfg_write(CFG_COUNT, 1);
        send(CMD_EVAL, 0, 32'h0000_0000);
        cfg_write(CFG_ORDER, 3);
        cfg_write(CFG_COUNT, 3);
        send(CMD_LOAD_KNOT, 0, 32'h0000_0000);
        send(CMD_LOAD_KNOT, 1, 32'h0001_0000);
        send(CMD_LOAD_KNOT, 2, 32'h0000_0000);
        send(CMD_EVAL, 0, 32'h0000_8000);
        send(CMD_EVAL, 0, 32'hFFFF_8000);

        run_phase(4, 8, 30, 0, 0, 0);
        run_phase(2, 5, 30, 1, 1, 0);
        run_phase(1, 6, 30, 1, 0, 1);
        run_phase(3, 10, 30, 1, 0, 0);
        run_phase(0, 4, 20, 1, 0, 0);
        run_phase(8, 64, 15, 1, 0, 0);
        run_phase(15, 127, 10, 1, 0, 0);
        run_phase(4, 0, 12, 1, 0, 0);
        run_phase(2, 1, 12, 1, 0, 0);
        run_phase(5, 12, 25, 1, 0, 0);
        run_phase(3, 2, 25, 1, 0, 0);
        run_phase(4, 16, 30, 1, 0, 0);
        run_phase(6, 7, 20, 1, 0, 0);

        drain();
        repeat (50) @(negedge i_clk);
        $display("Run covered %0d items over 13 random settings plus directed cases,", items_sent);
        $display("with %0d evaluate results checked in %0d cycles.", checked, cycles);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

/* files.f */
design/bdb_pkg.sv
design/bdb_tables.sv
design/bdb_arith.sv
design/bspline_de_boor_evaluator.sv
tb/bdb_eval_checker.sv
tb/bspline_de_boor_evaluator_tb.sv
